// File: src/ivrms_pkg.sv
// ----------------------------------------------------------------------------
// ivrms_pkg
// Shared types and constants for the interval to RMS velocity block.
// ----------------------------------------------------------------------------
package ivrms_pkg;

  // Configuration register indexes
  localparam logic [1:0] REG_THICKNESS = 2'd0;
  localparam logic [1:0] REG_ORIGIN    = 2'd1;
  localparam logic [1:0] REG_STEP      = 2'd2;
  localparam logic [1:0] REG_SAMPLES   = 2'd3;

  // Divider iteration counts (dividend bits, left aligned in 64)
  localparam logic [6:0] ITER_TIME  = 7'd41;
  localparam logic [6:0] ITER_INDEX = 7'd49;
  localparam logic [6:0] ITER_RATIO = 7'd64;

  // Square root: two radicand bits per step
  localparam logic [4:0] SQRT_STEPS = 5'd16;

  typedef enum logic [3:0] {
    ST_IDLE, ST_MUL, ST_DIV_T, ST_ACC, ST_EVAL, ST_DIV_Q,
    ST_CHK, ST_DIV_R, ST_SQRT, ST_FIN, ST_DONE
  } state_t;

  typedef enum logic [1:0] {
    DIV_TIME, DIV_INDEX, DIV_RATIO
  } div_sel_t;

  typedef struct packed {
    logic     load_in;
    logic     mul;
    logic     div_start;
    div_sel_t div_sel;
    logic     acc;
    logic     res_clear;
    logic     sqrt_start;
    logic     res_set;
    logic     out_load;
  } cmd_t;

  typedef struct packed {
    logic zero_v;
    logic div_busy;
    logic sqrt_busy;
    logic diff_pos;
    logic q_ok;
    logic out_full;
  } sts_t;

endpackage

// File: src/ivrms_div.sv
// ----------------------------------------------------------------------------
// ivrms_div
// Restoring divider, one quotient bit per cycle, dividend left aligned.
// ----------------------------------------------------------------------------
module ivrms_div (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [63:0] dividend,
  input  logic [47:0] divisor,
  input  logic [6:0]  iters,
  output logic        busy,
  output logic [63:0] quotient
);

  logic [6:0]  cnt;
  logic [63:0] sh;
  logic [47:0] rem;
  logic [47:0] dvs;
  logic [48:0] rem_sh;
  logic [48:0] rem_sub;
  logic        ge;

  // trial subtract against the divisor held since start
  always_comb begin
    rem_sh  = {rem, sh[63]};
    rem_sub = rem_sh - {1'b0, dvs};
    ge      = (rem_sh >= {1'b0, dvs});
  end

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= iters;
    end else if (busy) begin
      cnt <= cnt - 7'd1;
      if (cnt == 7'd1) busy <= 1'b0;
    end
  end

  // shift register: dividend bits out, quotient bits in
  always_ff @(posedge clk) begin
    if (start) begin
      sh  <= dividend;
      rem <= '0;
      dvs <= divisor;
    end else if (busy) begin
      sh  <= {sh[62:0], ge};
      rem <= ge ? rem_sub[47:0] : rem_sh[47:0];
    end
  end

  assign quotient = sh;

endmodule

// File: src/ivrms_dp.sv
// ----------------------------------------------------------------------------
// ivrms_dp
// Datapath: config registers, running sums, shared divider, square root,
// result and output registers.
// ----------------------------------------------------------------------------
module ivrms_dp (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_index,
  input  logic [23:0]        cfg_data,
  input  logic [15:0]        in_velocity,
  input  logic               in_start,
  input  ivrms_pkg::cmd_t    cmd,
  output ivrms_pkg::sts_t    sts,
  input  logic               m_tready,
  output logic               m_tvalid,
  output logic [31:0]        m_tdata,
  output logic [1:0]         m_tuser
);

  logic [23:0] thickness;
  logic [23:0] origin;
  logic [23:0] tstep;
  logic [15:0] samples;

  logic [15:0] vel;
  logic [47:0] sum_t;
  logic [63:0] sum_a;
  logic [56:0] da;

  logic [63:0] div_dividend;
  logic [47:0] div_divisor;
  logic [6:0]  div_iters;
  logic        div_busy;
  logic [63:0] quo;

  logic [48:0] sum_t_add;
  logic [64:0] sum_a_add;
  logic [49:0] diff;
  logic [23:0] step_eff;

  logic [31:0] sq_x;
  logic [17:0] sq_rem;
  logic [15:0] sq_root;
  logic [4:0]  sq_cnt;
  logic        sq_busy;
  logic [19:0] sq_t;
  logic [19:0] sq_trial;
  logic        sq_ge;

  logic [15:0] idx_hold;
  logic        ratio_big;
  logic [15:0] res_idx;
  logic [15:0] res_rms;
  logic        res_valid;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      thickness <= 24'd2560;
      origin    <= 24'd0;
      tstep     <= 24'd65536;
      samples   <= 16'd1024;
    end else if (cfg_we) begin
      unique case (cfg_index)
        ivrms_pkg::REG_THICKNESS: thickness <= cfg_data;
        ivrms_pkg::REG_ORIGIN:    origin    <= cfg_data;
        ivrms_pkg::REG_STEP:      tstep     <= cfg_data;
        ivrms_pkg::REG_SAMPLES:   samples   <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  assign step_eff = (tstep == 24'd0) ? 24'd1 : tstep;

  // saturating sums and signed offset
  always_comb begin
    sum_t_add = {1'b0, sum_t} + {8'd0, quo[40:0]};
    sum_a_add = {1'b0, sum_a} + {8'd0, da};
    diff      = $signed({2'b00, sum_t}) - $signed({{26{origin[23]}}, origin});
  end

  // running sums and input capture
  always_ff @(posedge clk) begin
    if (rst) begin
      sum_t <= '0;
      sum_a <= '0;
    end else if (cmd.load_in) begin
      if (in_start) begin
        sum_t <= '0;
        sum_a <= '0;
      end
    end else if (cmd.acc) begin
      sum_t <= sum_t_add[48] ? {48{1'b1}} : sum_t_add[47:0];
      sum_a <= sum_a_add[64] ? {64{1'b1}} : sum_a_add[63:0];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_in) vel <= in_velocity;
    if (cmd.mul) da <= {({16'd0, thickness} * {24'd0, vel}), 17'd0};
  end

  // divider operand select
  always_comb begin
    unique case (cmd.div_sel)
      ivrms_pkg::DIV_TIME: begin
        div_dividend = {thickness, 40'd0};
        div_divisor  = {32'd0, vel};
        div_iters    = ivrms_pkg::ITER_TIME;
      end
      ivrms_pkg::DIV_INDEX: begin
        div_dividend = {diff[48:0], 15'd0};
        div_divisor  = {24'd0, step_eff};
        div_iters    = ivrms_pkg::ITER_INDEX;
      end
      ivrms_pkg::DIV_RATIO: begin
        div_dividend = sum_a;
        div_divisor  = sum_t;
        div_iters    = ivrms_pkg::ITER_RATIO;
      end
      default: begin
        div_dividend = sum_a;
        div_divisor  = sum_t;
        div_iters    = ivrms_pkg::ITER_RATIO;
      end
    endcase
  end

  ivrms_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .iters    (div_iters),
    .busy     (div_busy),
    .quotient (quo)
  );

  // keep the index before the ratio division overwrites the quotient
  always_ff @(posedge clk) begin
    if (cmd.div_start && cmd.div_sel == ivrms_pkg::DIV_RATIO) idx_hold <= quo[15:0];
  end

  // digit-by-digit square root, two radicand bits per cycle
  always_comb begin
    sq_t     = {sq_rem, sq_x[31:30]};
    sq_trial = {2'b00, sq_root, 2'b01};
    sq_ge    = (sq_t >= sq_trial);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sq_busy <= 1'b0;
      sq_cnt  <= '0;
    end else if (cmd.sqrt_start) begin
      sq_busy <= 1'b1;
      sq_cnt  <= ivrms_pkg::SQRT_STEPS;
    end else if (sq_busy) begin
      sq_cnt <= sq_cnt - 5'd1;
      if (sq_cnt == 5'd1) sq_busy <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.sqrt_start) begin
      sq_x      <= quo[31:0];
      sq_rem    <= '0;
      sq_root   <= '0;
      ratio_big <= |quo[63:32];
    end else if (sq_busy) begin
      sq_x    <= {sq_x[29:0], 2'b00};
      sq_rem  <= sq_ge ? sq_t[17:0] - sq_trial[17:0] : sq_t[17:0];
      sq_root <= {sq_root[14:0], sq_ge};
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (cmd.res_clear) begin
      res_idx   <= '0;
      res_rms   <= '0;
      res_valid <= 1'b0;
    end else if (cmd.res_set) begin
      res_idx   <= idx_hold;
      res_rms   <= ratio_big ? 16'hFFFF : sq_root;
      res_valid <= 1'b1;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      m_tdata <= {res_rms, res_idx};
      m_tuser <= {(vel == 16'd0), res_valid};
    end
  end

  // status
  always_comb begin
    sts.zero_v    = (vel == 16'd0);
    sts.div_busy  = div_busy;
    sts.sqrt_busy = sq_busy;
    sts.diff_pos  = (sum_t != 48'd0) && !diff[49] && (diff != 50'd0);
    sts.q_ok      = (quo[48:0] != 49'd0) && (quo[48:0] < {33'd0, samples});
    sts.out_full  = m_tvalid && !m_tready;
  end

endmodule

// File: src/ivrms_ctrl.sv
// ----------------------------------------------------------------------------
// ivrms_ctrl
// Controller: steps one layer through multiply, divisions and square root.
// ----------------------------------------------------------------------------
module ivrms_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              s_tvalid,
  output logic              s_tready,
  input  ivrms_pkg::sts_t   sts,
  output ivrms_pkg::cmd_t   cmd
);

  ivrms_pkg::state_t state;
  ivrms_pkg::state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) state <= ivrms_pkg::ST_IDLE;
    else     state <= state_next;
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ivrms_pkg::ST_IDLE:  if (s_tvalid) state_next = ivrms_pkg::ST_MUL;
      ivrms_pkg::ST_MUL:   state_next = sts.zero_v ? ivrms_pkg::ST_EVAL : ivrms_pkg::ST_DIV_T;
      ivrms_pkg::ST_DIV_T: if (!sts.div_busy) state_next = ivrms_pkg::ST_ACC;
      ivrms_pkg::ST_ACC:   state_next = ivrms_pkg::ST_EVAL;
      ivrms_pkg::ST_EVAL:  state_next = sts.diff_pos ? ivrms_pkg::ST_DIV_Q : ivrms_pkg::ST_DONE;
      ivrms_pkg::ST_DIV_Q: if (!sts.div_busy) state_next = ivrms_pkg::ST_CHK;
      ivrms_pkg::ST_CHK:   state_next = sts.q_ok ? ivrms_pkg::ST_DIV_R : ivrms_pkg::ST_DONE;
      ivrms_pkg::ST_DIV_R: if (!sts.div_busy) state_next = ivrms_pkg::ST_SQRT;
      ivrms_pkg::ST_SQRT:  state_next = ivrms_pkg::ST_FIN;
      ivrms_pkg::ST_FIN:   if (!sts.sqrt_busy) state_next = ivrms_pkg::ST_DONE;
      ivrms_pkg::ST_DONE:  if (!sts.out_full) state_next = ivrms_pkg::ST_IDLE;
      default:             state_next = ivrms_pkg::ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    cmd         = '0;
    cmd.div_sel = ivrms_pkg::DIV_TIME;
    s_tready    = 1'b0;
    unique case (state)
      ivrms_pkg::ST_IDLE: begin
        s_tready    = 1'b1;
        cmd.load_in = s_tvalid;
      end
      ivrms_pkg::ST_MUL: begin
        cmd.mul       = 1'b1;
        cmd.div_start = !sts.zero_v;
      end
      ivrms_pkg::ST_ACC: cmd.acc = 1'b1;
      ivrms_pkg::ST_EVAL: begin
        cmd.div_sel   = ivrms_pkg::DIV_INDEX;
        cmd.div_start = sts.diff_pos;
        cmd.res_clear = !sts.diff_pos;
      end
      ivrms_pkg::ST_CHK: begin
        cmd.div_sel   = ivrms_pkg::DIV_RATIO;
        cmd.div_start = sts.q_ok;
        cmd.res_clear = !sts.q_ok;
      end
      ivrms_pkg::ST_SQRT: begin
        cmd.div_sel    = ivrms_pkg::DIV_RATIO;
        cmd.sqrt_start = 1'b1;
      end
      ivrms_pkg::ST_FIN:  cmd.res_set  = !sts.sqrt_busy;
      ivrms_pkg::ST_DONE: cmd.out_load = !sts.out_full;
      default: ;
    endcase
  end

endmodule

// File: src/interval_to_rms_velocity.sv
// Per layer the shared bit-serial divider runs, as the layer needs, 41 (layer
// time), 49 (sample index) and 64 (a/t) iterations, then 16 square root steps.
// One layer at a time: a new word is accepted only once the last is done;
// a finished word waits in the output register while the next layer runs.
// Reset (synchronous, rst high) clears sums, controller and output valid,
// and sets the configuration registers to their defaults.
// ----------------------------------------------------------------------------
// interval_to_rms_velocity
// Dix relation: running two-way time and velocity-weighted time per trace,
// output sample index and RMS velocity per depth layer.
// ----------------------------------------------------------------------------
module interval_to_rms_velocity (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [23:0] cfg_data,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,   // [15:0] interval_velocity
  input  logic        s_tuser,   // [0] trace_start
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,   // [15:0] time_index, [31:16] rms_velocity
  output logic [1:0]  m_tuser    // [0] index_valid, [1] zero_velocity
);

  ivrms_pkg::cmd_t cmd;
  ivrms_pkg::sts_t sts;

  ivrms_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  ivrms_dp u_dp (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .in_velocity (s_tdata),
    .in_start    (s_tuser),
    .cmd         (cmd),
    .sts         (sts),
    .m_tready    (m_tready),
    .m_tvalid    (m_tvalid),
    .m_tdata     (m_tdata),
    .m_tuser     (m_tuser)
  );

endmodule

// File: src/ivrms_checker.sv
// ----------------------------------------------------------------------------
// ivrms_checker
// Port-level checks for interval_to_rms_velocity.
// ----------------------------------------------------------------------------
module ivrms_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [31:0] m_tdata,
  input logic [1:0]  m_tuser
);

  // a stalled word stays presented
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid)
    else $error("output word dropped while stalled");

  // an invalid index carries zero index and velocity
  a_zero_res: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tuser[0] |-> m_tdata == 32'd0)
    else $error("invalid result with nonzero fields");

  // a valid index is never zero
  a_idx_pos: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser[0] |-> m_tdata[15:0] != 16'd0)
    else $error("valid result with zero index");

  // one layer at a time: busy right after acceptance
  a_busy: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("input accepted while busy");

  // no word leaves in the cycle after reset
  a_reset: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("output valid after reset");

endmodule

bind interval_to_rms_velocity ivrms_checker u_ivrms_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser)
);
